// File: rtl/core/sdspi_pkg.sv
// ----------------------------------------------------------------------------
// sdspi_pkg
// Types, constants and command frame table shared by the SD SPI init
// sequencer core, its step logic and its checker.
// ----------------------------------------------------------------------------
package sdspi_pkg;

  localparam logic [3:0] POLL_LIMIT = 4'd8;
  localparam logic [3:0] WAKE_BYTES = 4'd10;
  localparam int unsigned REPLY_LEN = 4;

  localparam logic [15:0] IDLE_TRIES_RST   = 16'd500;
  localparam logic [15:0] OPCOND_TRIES_RST = 16'd40000;
  localparam logic [7:0]  CHECK_PAT_RST    = 8'hAA;

  // command, argument, CRC and response bytes
  localparam logic [7:0] TOK_CMD0   = 8'h40;
  localparam logic [7:0] TOK_CMD8   = 8'h48;
  localparam logic [7:0] TOK_CMD58  = 8'h7A;
  localparam logic [7:0] TOK_CMD55  = 8'h77;
  localparam logic [7:0] TOK_ACMD41 = 8'h69;
  localparam logic [7:0] TOK_CMD16  = 8'h50;
  localparam logic [7:0] CRC_CMD0   = 8'h95;
  localparam logic [7:0] CRC_CMD8   = 8'h87;
  localparam logic [7:0] ARG_HCS    = 8'h40;
  localparam logic [7:0] ARG_VHS    = 8'h01;
  localparam logic [7:0] ARG_BLK512 = 8'h02;
  localparam logic [7:0] BYTE_IDLE  = 8'hFF;
  localparam logic [7:0] R1_IDLE    = 8'h01;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_NO_IDLE   = 3'd1;
  localparam logic [2:0] STAT_BAD_IF    = 3'd2;
  localparam logic [2:0] STAT_OPCOND_TO = 3'd3;
  localparam logic [2:0] STAT_OCR_TO    = 3'd4;

  typedef enum logic [1:0] {
    CFG_IDLE_TRIES    = 2'd0,
    CFG_OPCOND_TRIES  = 2'd1,
    CFG_CHECK_PATTERN = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WAKE,
    PH_SEL,
    PH_DONE,
    PH_CMD
  } phase_t;

  typedef enum logic [1:0] {
    ST_PRE,
    ST_SEND,
    ST_POLL,
    ST_RECV
  } step_t;

  typedef enum logic [2:0] {
    C_GO,
    C_IF,
    C_OCR,
    C_APP,
    C_OP,
    C_OCR2,
    C_BLEN
  } cmd_id_t;

  typedef struct packed {
    logic [15:0] idle_tries;
    logic [15:0] opcond_tries;
    logic [7:0]  check_pattern;
  } cfg_t;

  typedef struct packed {
    phase_t                        phase;
    cmd_id_t                       cmd_id;
    step_t                         step;
    logic [2:0]                    byte_idx;  // status code once done
    logic [3:0]                    poll_cnt;
    logic [15:0]                   try_cnt;
    logic [REPLY_LEN-2:0][7:0]     reply;     // last byte comes straight from rx
    logic                          ccs;
    logic                          busy;
    logic                          v1;
  } state_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       select_active;
    logic       done_res;
    logic [2:0] status;
    logic       high_capacity;
    logic       version_one_card;
  } result_t;

  localparam state_t STATE_RST = '{
    phase:    PH_IDLE,
    cmd_id:   C_GO,
    step:     ST_PRE,
    byte_idx: 3'd0,
    poll_cnt: 4'd0,
    try_cnt:  16'd0,
    reply:    '0,
    ccs:      1'b0,
    busy:     1'b0,
    v1:       1'b0
  };

  // byte k of the six-byte command frame
  function automatic logic [7:0] frame_byte(cmd_id_t id, logic [2:0] k,
                                            logic [7:0] pattern, logic ccs);
    logic [5:0][7:0] f;
    logic [2:0]      kk;
    f    = '0;
    f[5] = BYTE_IDLE;
    case (id)
      C_GO: begin
        f[0] = TOK_CMD0;
        f[5] = CRC_CMD0;
      end
      C_IF: begin
        f[0] = TOK_CMD8;
        f[3] = ARG_VHS;
        f[4] = pattern;
        f[5] = CRC_CMD8;
      end
      C_OCR, C_OCR2: begin
        f[0] = TOK_CMD58;
      end
      C_APP: begin
        f[0] = TOK_CMD55;
        f[1] = ccs ? ARG_HCS : 8'h00;
      end
      C_OP: begin
        f[0] = TOK_ACMD41;
        f[1] = ARG_HCS;
      end
      default: begin
        f[0] = TOK_CMD16;
        f[3] = ARG_BLK512;
      end
    endcase
    kk = (k < 3'd6) ? k : 3'd5;
    return f[kk];
  endfunction

endpackage

// File: rtl/core/sdspi_step.sv
// ----------------------------------------------------------------------------
// sdspi_step
// Next-state and result logic for one byte exchange of the init sequence.
// ----------------------------------------------------------------------------
module sdspi_step (
  input  sdspi_pkg::state_t  state,
  input  sdspi_pkg::cfg_t    cfg,
  input  logic               cmd,
  input  logic [7:0]         rx_byte,
  output sdspi_pkg::state_t  state_nxt,
  output sdspi_pkg::result_t res
);

  function automatic sdspi_pkg::state_t begin_cmd(sdspi_pkg::state_t s,
                                                  sdspi_pkg::cmd_id_t id);
    sdspi_pkg::state_t n;
    n        = s;
    n.phase  = sdspi_pkg::PH_CMD;
    n.cmd_id = id;
    n.step   = sdspi_pkg::ST_PRE;
    return n;
  endfunction

  function automatic sdspi_pkg::state_t begin_recv(sdspi_pkg::state_t s,
                                                   sdspi_pkg::cmd_id_t id);
    sdspi_pkg::state_t n;
    n          = s;
    n.phase    = sdspi_pkg::PH_CMD;
    n.cmd_id   = id;
    n.step     = sdspi_pkg::ST_RECV;
    n.byte_idx = 3'd0;
    return n;
  endfunction

  function automatic sdspi_pkg::state_t finish(sdspi_pkg::state_t s, logic [2:0] code);
    sdspi_pkg::state_t n;
    n          = s;
    n.phase    = sdspi_pkg::PH_DONE;
    n.byte_idx = code;
    return n;
  endfunction

  function automatic sdspi_pkg::state_t card_ready(sdspi_pkg::state_t s,
                                                   logic [15:0] limit);
    sdspi_pkg::state_t n;
    if (s.try_cnt >= limit) begin
      n = finish(s, sdspi_pkg::STAT_OCR_TO);
    end else if (!s.ccs) begin
      n = begin_cmd(s, sdspi_pkg::C_BLEN);
    end else begin
      n = finish(s, sdspi_pkg::STAT_OK);
    end
    return n;
  endfunction

  function automatic sdspi_pkg::state_t ocr_retry(sdspi_pkg::state_t s,
                                                  logic [15:0] limit);
    sdspi_pkg::state_t n;
    n = s;
    if (s.try_cnt >= limit) begin
      n = finish(s, sdspi_pkg::STAT_OCR_TO);
    end else begin
      n.try_cnt = s.try_cnt + 16'd1;
      n = begin_cmd(n, sdspi_pkg::C_OCR2);
    end
    return n;
  endfunction

  // next state
  always_comb begin
    sdspi_pkg::state_t n;
    logic [15:0]       try_inc;
    logic [7:0]        b0;
    n       = state;
    try_inc = state.try_cnt + 16'd1;
    b0      = state.reply[0];
    if (!cmd) begin
      n          = state;
      n.byte_idx = 3'd0;
      n.try_cnt  = 16'd0;
      n.ccs      = 1'b0;
      n.busy     = 1'b0;
      n.v1       = 1'b0;
      n.phase    = sdspi_pkg::PH_WAKE;
      n.poll_cnt = 4'd1;
    end else begin
      case (state.phase)
        sdspi_pkg::PH_WAKE: begin
          if (state.poll_cnt < sdspi_pkg::WAKE_BYTES) begin
            n.poll_cnt = state.poll_cnt + 4'd1;
          end else begin
            n.phase = sdspi_pkg::PH_SEL;
          end
        end
        sdspi_pkg::PH_SEL: begin
          n = begin_cmd(state, sdspi_pkg::C_GO);
        end
        sdspi_pkg::PH_CMD: begin
          case (state.step)
            sdspi_pkg::ST_PRE: begin
              n.step     = sdspi_pkg::ST_SEND;
              n.byte_idx = 3'd0;
            end
            sdspi_pkg::ST_SEND: begin
              if (state.byte_idx < 3'd5) begin
                n.byte_idx = state.byte_idx + 3'd1;
              end else begin
                n.step     = sdspi_pkg::ST_POLL;
                n.poll_cnt = 4'd1;
              end
            end
            sdspi_pkg::ST_POLL: begin
              if (rx_byte == sdspi_pkg::BYTE_IDLE &&
                  state.poll_cnt < sdspi_pkg::POLL_LIMIT) begin
                n.poll_cnt = state.poll_cnt + 4'd1;
              end else begin
                // response byte
                case (state.cmd_id)
                  sdspi_pkg::C_GO: begin
                    if (rx_byte == sdspi_pkg::R1_IDLE) begin
                      n.try_cnt = 16'd0;
                      n = begin_cmd(n, sdspi_pkg::C_IF);
                    end else begin
                      n.try_cnt = try_inc;
                      if (try_inc >= cfg.idle_tries) begin
                        n = finish(n, sdspi_pkg::STAT_NO_IDLE);
                      end else begin
                        n = begin_cmd(n, sdspi_pkg::C_GO);
                      end
                    end
                  end
                  sdspi_pkg::C_IF: begin
                    if (!rx_byte[2]) begin
                      n = begin_recv(n, sdspi_pkg::C_IF);
                    end else begin
                      // illegal command: version 1 card
                      n.v1 = 1'b1;
                      n = begin_cmd(n, sdspi_pkg::C_OCR);
                    end
                  end
                  sdspi_pkg::C_OCR, sdspi_pkg::C_OCR2: begin
                    n = begin_recv(n, state.cmd_id);
                  end
                  sdspi_pkg::C_APP: begin
                    n = begin_cmd(n, sdspi_pkg::C_OP);
                  end
                  sdspi_pkg::C_OP: begin
                    if (!rx_byte[0]) begin
                      if (state.busy) begin
                        n = ocr_retry(n, cfg.opcond_tries);
                      end else begin
                        n = card_ready(n, cfg.opcond_tries);
                      end
                    end else begin
                      n.try_cnt = try_inc;
                      if (try_inc >= cfg.opcond_tries) begin
                        n = finish(n, sdspi_pkg::STAT_OPCOND_TO);
                      end else begin
                        n = begin_cmd(n, sdspi_pkg::C_APP);
                      end
                    end
                  end
                  default: begin
                    n = finish(n, sdspi_pkg::STAT_OK);
                  end
                endcase
              end
            end
            default: begin
              // ST_RECV: four reply bytes, the last one is used straight from rx
              for (int i = 0; i < sdspi_pkg::REPLY_LEN - 1; i++) begin
                if (state.byte_idx[1:0] == i[1:0]) begin
                  n.reply[i] = rx_byte;
                end
              end
              if (state.byte_idx < 3'(sdspi_pkg::REPLY_LEN - 1)) begin
                n.byte_idx = state.byte_idx + 3'd1;
              end else if (state.cmd_id == sdspi_pkg::C_IF) begin
                if (!state.reply[2][0] || rx_byte != cfg.check_pattern) begin
                  n = finish(n, sdspi_pkg::STAT_BAD_IF);
                end else begin
                  n = begin_cmd(n, sdspi_pkg::C_OCR);
                end
              end else if (state.cmd_id == sdspi_pkg::C_OCR) begin
                if (b0[7]) begin
                  n.ccs = b0[6];
                end else begin
                  n.busy = 1'b1;
                end
                n.try_cnt = 16'd0;
                n = begin_cmd(n, sdspi_pkg::C_APP);
              end else begin
                n.ccs  = b0[6];
                n.busy = ~b0[7];
                if (!b0[7]) begin
                  n = ocr_retry(n, cfg.opcond_tries);
                end else begin
                  n = card_ready(n, cfg.opcond_tries);
                end
              end
            end
          endcase
        end
        default: begin
          // idle or done: a report changes nothing
          n = state;
        end
      endcase
    end
    state_nxt = n;
  end

  // result follows from the new state
  always_comb begin
    logic active;
    active = (state_nxt.phase == sdspi_pkg::PH_WAKE) ||
             (state_nxt.phase == sdspi_pkg::PH_SEL)  ||
             (state_nxt.phase == sdspi_pkg::PH_CMD);
    res.tx_valid = active;
    if (!active) begin
      res.tx_byte = 8'h00;
    end else if (state_nxt.phase == sdspi_pkg::PH_CMD &&
                 state_nxt.step == sdspi_pkg::ST_SEND) begin
      res.tx_byte = sdspi_pkg::frame_byte(state_nxt.cmd_id, state_nxt.byte_idx,
                                          cfg.check_pattern, state_nxt.ccs);
    end else begin
      res.tx_byte = sdspi_pkg::BYTE_IDLE;
    end
    res.select_active    = (state_nxt.phase != sdspi_pkg::PH_IDLE) &&
                           (state_nxt.phase != sdspi_pkg::PH_WAKE);
    res.done_res         = (state_nxt.phase == sdspi_pkg::PH_DONE);
    res.status           = res.done_res ? state_nxt.byte_idx : sdspi_pkg::STAT_OK;
    res.high_capacity    = state_nxt.ccs;
    res.version_one_card = state_nxt.v1;
  end

endmodule

// File: rtl/core/sd_spi_init_sequencer_core.sv
// ----------------------------------------------------------------------------
// sd_spi_init_sequencer_core
// SD card SPI-mode start-up sequencer: one transaction in per byte exchange,
// one transaction out with the next byte to send and the sequence status.
//
//   channel | ports                      | transaction
//   --------+----------------------------+------------------------------------
//   in      | in_valid/in_ready, in_*    | start (cmd 0) or received byte
//   out     | out_valid/out_ready, out_* | next tx byte, select, status, flags
//   cfg     | cfg_we, cfg_index, cfg_wdata | register write, no wait
//
// One transaction per cycle while out_ready is high; each passes the
// input register, then the step logic into the result register.
// The sequencer state updates when a transaction moves from the input
// register into the result register.
// Synchronous active-low reset puts the sequencer in idle and loads the
// register defaults. out_ready low holds the result; one more transaction
// is taken into the input register before in_ready drops.
// ----------------------------------------------------------------------------
module sd_spi_init_sequencer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_tx_byte,
  output logic        out_tx_valid,
  output logic        out_select_active,
  output logic        out_done_res,
  output logic [2:0]  out_status,
  output logic        out_high_capacity,
  output logic        out_version_one_card,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic               in_vld_r;
  logic               in_cmd_r;
  logic [7:0]         in_rx_r;
  logic               out_vld_r;
  logic               adv;
  sdspi_pkg::state_t  state_r;
  sdspi_pkg::state_t  state_nxt;
  sdspi_pkg::result_t res_nxt;
  sdspi_pkg::result_t res_r;
  sdspi_pkg::cfg_t    cfg_r;

  assign adv      = !out_vld_r || out_ready;
  assign in_ready = !in_vld_r || adv;

  sdspi_step u_step (
    .state     (state_r),
    .cfg       (cfg_r),
    .cmd       (in_cmd_r),
    .rx_byte   (in_rx_r),
    .state_nxt (state_nxt),
    .res       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      state_r   <= sdspi_pkg::STATE_RST;
      cfg_r     <= '{idle_tries:    sdspi_pkg::IDLE_TRIES_RST,
                     opcond_tries:  sdspi_pkg::OPCOND_TRIES_RST,
                     check_pattern: sdspi_pkg::CHECK_PAT_RST};
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (adv) begin
        out_vld_r <= in_vld_r;
        if (in_vld_r) begin
          state_r <= state_nxt;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          sdspi_pkg::CFG_IDLE_TRIES:    cfg_r.idle_tries    <= cfg_wdata;
          sdspi_pkg::CFG_OPCOND_TRIES:  cfg_r.opcond_tries  <= cfg_wdata;
          sdspi_pkg::CFG_CHECK_PATTERN: cfg_r.check_pattern <= cfg_wdata[7:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_cmd_r <= in_cmd;
      in_rx_r  <= in_rx_byte;
    end
    if (adv && in_vld_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid            = out_vld_r;
  assign out_tx_byte          = res_r.tx_byte;
  assign out_tx_valid         = res_r.tx_valid;
  assign out_select_active    = res_r.select_active;
  assign out_done_res         = res_r.done_res;
  assign out_status           = res_r.status;
  assign out_high_capacity    = res_r.high_capacity;
  assign out_version_one_card = res_r.version_one_card;

endmodule

// File: rtl/core/sdspi_checker.sv
// ----------------------------------------------------------------------------
// sdspi_checker
// Port-level checks for the SD SPI init sequencer core, bound to the top.
// ----------------------------------------------------------------------------
module sdspi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_tx_byte,
  input logic        out_tx_valid,
  input logic        out_select_active,
  input logic        out_done_res,
  input logic [2:0]  out_status,
  input logic        out_high_capacity,
  input logic        out_version_one_card
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tx_byte) &&
                                $stable(out_status))
    else $error("result changed while stalled");

  // input side only backs up behind a stalled result
  a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("in_ready low without pending result");

  // a finished sequence keeps select on and sends nothing
  a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> out_select_active && !out_tx_valid &&
                                  out_tx_byte == 8'h00)
    else $error("done result with byte to send");

  // status only while done
  a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_done_res |-> out_status == sdspi_pkg::STAT_OK)
    else $error("status set before done");

  // flags are clear before chip select comes on
  a_flags_wake: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_select_active |-> !out_high_capacity &&
                                        !out_version_one_card)
    else $error("card flags set during wake-up");

endmodule

bind sd_spi_init_sequencer_core sdspi_checker u_sdspi_checker (.*);
